### design/palette_merge_and_remap_defines.svh
// Assertion macros for the palette merge and remap block.
// Included by the top level; defining NO_ASSERTIONS leaves the bodies empty.
`ifndef PALETTE_MERGE_AND_REMAP_DEFINES_SVH
`define PALETTE_MERGE_AND_REMAP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PMR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmr assertion failed");
`define PMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmr assertion failed");
`else
`define PMR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/pmr_pkg.sv
// Package for the palette merge and remap block.
// Holds opcodes, status codes, field widths and the controller state type.
package pmr_pkg;

    localparam int OPCODE_W  = 3;
    localparam int COLOR_W   = 8;
    localparam int RGB_W     = 24;
    localparam int INDEX_W   = 8;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 3;

    localparam logic [OPCODE_W-1:0] OP_CLEAR       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_LARGE_ENTRY = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SMALL_ENTRY = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_LARGE_PIXEL = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SMALL_PIXEL = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd4;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_SCAN      = 6'b000010,
        S_APPEND    = 6'b000100,
        S_PIX_MAP   = 6'b001000,
        S_PIX_COLOR = 6'b010000,
        S_EMIT      = 6'b100000
    } state_t;

endpackage

### design/pmr_item_if.sv
// Input channel of the palette merge and remap block.
// Valid/ready handshake with the item fields; widths come from pmr_pkg.
interface pmr_item_if;
    logic                              valid;
    logic                              ready;
    logic [pmr_pkg::OPCODE_W-1:0]      opcode;
    logic [pmr_pkg::COLOR_W-1:0]       red;
    logic [pmr_pkg::COLOR_W-1:0]       green;
    logic [pmr_pkg::COLOR_W-1:0]       blue;
    logic [pmr_pkg::INDEX_W-1:0]       pixel_index;
    logic                              last_in_run;

    modport source (
        output valid, opcode, red, green, blue, pixel_index, last_in_run,
        input  ready
    );
    modport sink (
        input  valid, opcode, red, green, blue, pixel_index, last_in_run,
        output ready
    );
endinterface

### design/pmr_result_if.sv
// Result channel of the palette merge and remap block.
// Valid/ready handshake with the result fields; widths come from pmr_pkg.
interface pmr_result_if;
    logic                              valid;
    logic                              ready;
    logic [pmr_pkg::INDEX_W-1:0]       merged_index;
    logic                              is_new;
    logic [pmr_pkg::COLOR_W-1:0]       out_red;
    logic [pmr_pkg::COLOR_W-1:0]       out_green;
    logic [pmr_pkg::COLOR_W-1:0]       out_blue;
    logic [pmr_pkg::COUNT_W-1:0]       merged_count;
    logic [pmr_pkg::STATUS_W-1:0]      status;
    logic                              last_out;

    modport source (
        output valid, merged_index, is_new, out_red, out_green, out_blue,
               merged_count, status, last_out,
        input  ready
    );
    modport sink (
        input  valid, merged_index, is_new, out_red, out_green, out_blue,
               merged_count, status, last_out,
        output ready
    );
endinterface

### design/palette_merge_and_remap.sv
// Top level of the palette merge and remap block.
// Uses pmr_pkg, pmr_item_if, pmr_result_if and palette_merge_and_remap_defines.svh.
//
// Usage: items arrive on the valid/ready channel "items"; each item gives exactly one
// result on the valid/ready channel "results", in order. An item is taken only while the
// controller is idle, one item at a time; the merged color table and the two index maps
// live in synchronous memories with a registered read.
// Path from acceptance to result valid:
//   clear, error and rejected items: straight to S_EMIT.
//   pixel remap: map read (S_PIX_MAP), then color read (S_PIX_COLOR), then S_EMIT.
//   palette entry: S_SCAN reads the table one entry per cycle up to the matching merged
//   color; a new color (or an empty table) goes on to S_APPEND; then S_EMIT.
// The next item can be accepted in the cycle after its predecessor's result is loaded
// into the output register, so an item is taken only once the one before it is there.
// Reset clears the counters, the failure flag and the output valid; memory contents stay
// undefined and need no clearing, since the loaded counts guard every read.
// When the receiver stalls, one finished result waits in the output register while the
// next item is accepted and worked on; that item then holds in its last state until the
// output register frees.
module palette_merge_and_remap #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pmr_item_if.sink             items,
    pmr_result_if.source         results
);

    localparam int IDX_W   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(PALETTE_ENTRIES + 1);
    localparam int OUT_IDX = pmr_pkg::INDEX_W;
    localparam int OUT_CNT = pmr_pkg::COUNT_W;
    localparam int RGB_W   = pmr_pkg::RGB_W;

    pmr_pkg::state_t         state_reg, state_next;

    logic [CNT_W-1:0]        used_reg, used_next;
    logic [CNT_W-1:0]        large_loaded_reg, large_loaded_next;
    logic [CNT_W-1:0]        small_loaded_reg, small_loaded_next;
    logic                    failed_reg, failed_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    sel_reg, sel_next;
    logic [RGB_W-1:0]        rgb_reg, rgb_next;
    logic                    last_reg, last_next;
    logic [IDX_W-1:0]        scan_reg, scan_next;

    logic [IDX_W-1:0]        res_index_reg, res_index_next;
    logic                    res_new_reg, res_new_next;
    logic [RGB_W-1:0]        res_rgb_reg, res_rgb_next;
    logic [2:0]              res_status_reg, res_status_next;

    logic [OUT_IDX-1:0]      out_index_reg, out_index_next;
    logic                    out_new_reg, out_new_next;
    logic [RGB_W-1:0]        out_rgb_reg, out_rgb_next;
    logic [OUT_CNT-1:0]      out_count_reg, out_count_next;
    logic [2:0]              out_status_reg, out_status_next;
    logic                    out_last_reg, out_last_next;

    logic [RGB_W-1:0]        table_mem [PALETTE_ENTRIES];
    logic [RGB_W-1:0]        table_rdata_reg;
    logic [IDX_W-1:0]        table_raddr;
    logic                    table_we;

    logic [IDX_W-1:0]        map_mem [2**(IDX_W+1)];
    logic [IDX_W-1:0]        map_rdata_reg;
    logic [IDX_W:0]          map_raddr;
    logic [IDX_W:0]          map_waddr;
    logic [IDX_W-1:0]        map_wdata;
    logic                    map_we;

    logic                    in_small;
    logic [CNT_W-1:0]        in_loaded;
    logic [CNT_W-1:0]        cur_loaded;
    logic [RGB_W-1:0]        in_rgb;

    logic                    clear_fire;
    logic                    res_error;
    logic                    res_blank;

    assign in_small   = (items.opcode == pmr_pkg::OP_SMALL_ENTRY) ||
                        (items.opcode == pmr_pkg::OP_SMALL_PIXEL);
    assign in_loaded  = in_small ? small_loaded_reg : large_loaded_reg;
    assign cur_loaded = sel_reg ? small_loaded_reg : large_loaded_reg;
    assign in_rgb     = {items.red, items.green, items.blue};
    assign map_raddr  = {in_small, items.pixel_index[IDX_W-1:0]};
    assign map_waddr  = {sel_reg, cur_loaded[IDX_W-1:0]};

    assign items.ready = (state_reg == pmr_pkg::S_IDLE);

    assign results.valid        = out_valid_reg;
    assign results.merged_index = out_index_reg;
    assign results.is_new       = out_new_reg;
    assign results.out_red      = out_rgb_reg[23:16];
    assign results.out_green    = out_rgb_reg[15:8];
    assign results.out_blue     = out_rgb_reg[7:0];
    assign results.merged_count = out_count_reg;
    assign results.status       = out_status_reg;
    assign results.last_out     = out_last_reg;

    assign clear_fire = items.valid && items.ready && (items.opcode == pmr_pkg::OP_CLEAR);
    assign res_error  = out_valid_reg && (out_status_reg != pmr_pkg::ST_OK);
    assign res_blank  = (out_index_reg == '0) && (out_rgb_reg == '0) && !out_new_reg;

    always_comb
    begin
        state_next        = state_reg;
        used_next         = used_reg;
        large_loaded_next = large_loaded_reg;
        small_loaded_next = small_loaded_reg;
        failed_next       = failed_reg;
        out_valid_next    = out_valid_reg;
        sel_next          = sel_reg;
        rgb_next          = rgb_reg;
        last_next         = last_reg;
        scan_next         = scan_reg;
        res_index_next    = res_index_reg;
        res_new_next      = res_new_reg;
        res_rgb_next      = res_rgb_reg;
        res_status_next   = res_status_reg;
        out_index_next    = out_index_reg;
        out_new_next      = out_new_reg;
        out_rgb_next      = out_rgb_reg;
        out_count_next    = out_count_reg;
        out_status_next   = out_status_reg;
        out_last_next     = out_last_reg;
        table_raddr       = '0;
        table_we          = 1'b0;
        map_we            = 1'b0;
        map_wdata         = '0;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pmr_pkg::S_IDLE:
            begin
                if (items.valid)
                begin
                    sel_next        = in_small;
                    rgb_next        = in_rgb;
                    last_next       = items.last_in_run;
                    res_index_next  = '0;
                    res_new_next    = 1'b0;
                    res_rgb_next    = '0;
                    res_status_next = pmr_pkg::ST_OK;
                    state_next      = pmr_pkg::S_EMIT;
                    unique case (items.opcode) inside
                        pmr_pkg::OP_CLEAR:
                        begin
                            used_next         = '0;
                            large_loaded_next = '0;
                            small_loaded_next = '0;
                            failed_next       = 1'b0;
                        end
                        pmr_pkg::OP_LARGE_ENTRY, pmr_pkg::OP_SMALL_ENTRY:
                        begin
                            if (failed_reg)
                            begin
                                res_status_next = pmr_pkg::ST_FAILED;
                            end
                            else if (!in_small && (small_loaded_reg != '0))
                            begin
                                res_status_next = pmr_pkg::ST_ORDER;
                            end
                            else if (in_loaded >= CNT_W'(PALETTE_ENTRIES))
                            begin
                                res_status_next = pmr_pkg::ST_OVERFLOW;
                                failed_next     = 1'b1;
                            end
                            else if (used_reg == '0)
                            begin
                                state_next = pmr_pkg::S_APPEND;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = pmr_pkg::S_SCAN;
                            end
                        end
                        pmr_pkg::OP_LARGE_PIXEL, pmr_pkg::OP_SMALL_PIXEL:
                        begin
                            if (failed_reg)
                            begin
                                res_status_next = pmr_pkg::ST_FAILED;
                            end
                            else if (OUT_CNT'(items.pixel_index) >= OUT_CNT'(in_loaded))
                            begin
                                res_status_next = pmr_pkg::ST_RANGE;
                                failed_next     = 1'b1;
                            end
                            else
                            begin
                                state_next = pmr_pkg::S_PIX_MAP;
                            end
                        end
                        default:
                        begin
                            res_status_next = pmr_pkg::ST_ORDER;
                        end
                    endcase
                end
            end
            pmr_pkg::S_SCAN:
            begin
                table_raddr = IDX_W'(CNT_W'(scan_reg) + CNT_W'(1));
                if (table_rdata_reg == rgb_reg)
                begin
                    map_we         = 1'b1;
                    map_wdata      = scan_reg;
                    res_index_next = scan_reg;
                    res_rgb_next   = rgb_reg;
                    if (sel_reg)
                    begin
                        small_loaded_next = small_loaded_reg + CNT_W'(1);
                    end
                    else
                    begin
                        large_loaded_next = large_loaded_reg + CNT_W'(1);
                    end
                    state_next = pmr_pkg::S_EMIT;
                end
                else if ((CNT_W'(scan_reg) + CNT_W'(1)) < used_reg)
                begin
                    scan_next = IDX_W'(CNT_W'(scan_reg) + CNT_W'(1));
                end
                else
                begin
                    state_next = pmr_pkg::S_APPEND;
                end
            end
            pmr_pkg::S_APPEND:
            begin
                if (used_reg >= CNT_W'(PALETTE_ENTRIES))
                begin
                    res_status_next = pmr_pkg::ST_OVERFLOW;
                    failed_next     = 1'b1;
                end
                else
                begin
                    table_we       = 1'b1;
                    map_we         = 1'b1;
                    map_wdata      = used_reg[IDX_W-1:0];
                    res_index_next = used_reg[IDX_W-1:0];
                    res_new_next   = 1'b1;
                    res_rgb_next   = rgb_reg;
                    used_next      = used_reg + CNT_W'(1);
                    if (sel_reg)
                    begin
                        small_loaded_next = small_loaded_reg + CNT_W'(1);
                    end
                    else
                    begin
                        large_loaded_next = large_loaded_reg + CNT_W'(1);
                    end
                end
                state_next = pmr_pkg::S_EMIT;
            end
            pmr_pkg::S_PIX_MAP:
            begin
                table_raddr    = map_rdata_reg;
                res_index_next = map_rdata_reg;
                state_next     = pmr_pkg::S_PIX_COLOR;
            end
            pmr_pkg::S_PIX_COLOR:
            begin
                res_rgb_next = table_rdata_reg;
                state_next   = pmr_pkg::S_EMIT;
            end
            pmr_pkg::S_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = OUT_IDX'(res_index_reg);
                    out_new_next    = res_new_reg;
                    out_rgb_next    = res_rgb_reg;
                    out_count_next  = OUT_CNT'(used_reg);
                    out_status_next = res_status_reg;
                    out_last_next   = last_reg;
                    state_next      = pmr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pmr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pmr_pkg::S_IDLE;
            used_reg         <= '0;
            large_loaded_reg <= '0;
            small_loaded_reg <= '0;
            failed_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            used_reg         <= used_next;
            large_loaded_reg <= large_loaded_next;
            small_loaded_reg <= small_loaded_next;
            failed_reg       <= failed_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg        <= sel_next;
        rgb_reg        <= rgb_next;
        last_reg       <= last_next;
        scan_reg       <= scan_next;
        res_index_reg  <= res_index_next;
        res_new_reg    <= res_new_next;
        res_rgb_reg    <= res_rgb_next;
        res_status_reg <= res_status_next;
        out_index_reg  <= out_index_next;
        out_new_reg    <= out_new_next;
        out_rgb_reg    <= out_rgb_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (table_we)
        begin
            table_mem[used_reg[IDX_W-1:0]] <= rgb_reg;
        end
        table_rdata_reg <= table_mem[table_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[map_raddr];
    end

    `include "palette_merge_and_remap_defines.svh"

    `PMR_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid_reg, out_count_reg <= OUT_CNT'(PALETTE_ENTRIES))
    `PMR_ASSERT_IMP(a_new_is_ok, clk, rst_n, out_valid_reg && out_new_reg, out_status_reg == pmr_pkg::ST_OK)
    `PMR_ASSERT_IMP(a_error_zero, clk, rst_n, res_error, res_blank)
    `PMR_ASSERT_NEXT(a_clear_empties, clk, rst_n, clear_fire, (used_reg == '0) && !failed_reg)

endmodule

### tb/tb_top.sv
// Self-checking testbench for palette_merge_and_remap: directed and random palette jobs
// drive the item channel and every result is checked against an in-bench model of the merge.
// Depends on pmr_pkg, pmr_item_if, pmr_result_if and the palette_merge_and_remap RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int PAL_N        = 256;
    localparam int ITEM_TARGET  = 1850;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 300;
    localparam int MAX_REPORTS  = 10;

    localparam int OPC_W = pmr_pkg::OPCODE_W;
    localparam int CLR_W = pmr_pkg::COLOR_W;
    localparam int RGB_W = pmr_pkg::RGB_W;
    localparam int IDX_W = pmr_pkg::INDEX_W;
    localparam int CNT_W = pmr_pkg::COUNT_W;
    localparam int STS_W = pmr_pkg::STATUS_W;

    localparam logic [OPC_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OPC_W-1:0] OP_UNUSED_LAST  = 3'd7;

    localparam int JOB_FILL_MERGED    = 0;
    localparam int JOB_OVERFILL_LARGE = 1;
    localparam int JOB_OVERFILL_SMALL = 2;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [CLR_W-1:0] red;
        logic [CLR_W-1:0] green;
        logic [CLR_W-1:0] blue;
        logic [IDX_W-1:0] pixel_index;
        logic             last_in_run;
    } pal_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] merged_index;
        logic             is_new;
        logic [CLR_W-1:0] red;
        logic [CLR_W-1:0] green;
        logic [CLR_W-1:0] blue;
        logic [CNT_W-1:0] merged_count;
        logic [STS_W-1:0] status;
        logic             last_out;
    } pal_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pmr_item_if   item_bus();
    pmr_result_if result_bus();

    palette_merge_and_remap #(
        .PALETTE_ENTRIES(PAL_N)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_bus),
        .results (result_bus)
    );

    pal_item_t   items_to_send[$];
    pal_result_t merged_results_due[$];
    pal_item_t   on_bus;
    bit          item_taken;
    bit          src_steady;
    bit          sink_steady;
    bit          noisy;
    bit          drained;
    int          gap_left;
    int          stall_left;
    int          work_items;
    int          queued_total;
    int          accepted;
    int          mismatches;
    int          cycle_count;

    logic [RGB_W-1:0] merged_rgb [PAL_N];
    logic [IDX_W-1:0] large_slots [PAL_N];
    logic [IDX_W-1:0] small_slots [PAL_N];
    int               colors_used;
    int               large_cnt;
    int               small_cnt;
    bit               job_dead;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        if (p < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string describe(pal_result_t r);
        return $sformatf("index=%0d new=%0d rgb=%02h%02h%02h count=%0d status=%0d last=%0d",
                         r.merged_index, r.is_new, r.red, r.green, r.blue, r.merged_count,
                         r.status, r.last_out);
    endfunction

    function automatic pal_result_t predict_merge(pal_item_t it);
        pal_result_t      r;
        logic [RGB_W-1:0] rgb;
        int               slot;
        int               j;
        bit               large_side;
        r = '0;
        r.last_out = it.last_in_run;
        rgb = {it.red, it.green, it.blue};
        slot = -1;
        large_side = (it.opcode == pmr_pkg::OP_LARGE_ENTRY) ||
                     (it.opcode == pmr_pkg::OP_LARGE_PIXEL);
        if (it.opcode > pmr_pkg::OP_SMALL_PIXEL)
            r.status = pmr_pkg::ST_ORDER;
        else if (it.opcode == pmr_pkg::OP_CLEAR)
        begin
            colors_used = 0;
            large_cnt = 0;
            small_cnt = 0;
            job_dead = 1'b0;
        end
        else if (job_dead)
            r.status = pmr_pkg::ST_FAILED;
        else if (it.opcode == pmr_pkg::OP_LARGE_ENTRY && small_cnt != 0)
            r.status = pmr_pkg::ST_ORDER;
        else if (it.opcode == pmr_pkg::OP_LARGE_ENTRY || it.opcode == pmr_pkg::OP_SMALL_ENTRY)
        begin
            if ((large_side ? large_cnt : small_cnt) >= PAL_N)
            begin
                job_dead = 1'b1;
                r.status = pmr_pkg::ST_OVERFLOW;
            end
            else
            begin
                for (j = 0; j < colors_used && slot < 0; j++)
                    if (merged_rgb[j] == rgb)
                        slot = j;
                if (slot < 0 && colors_used >= PAL_N)
                begin
                    job_dead = 1'b1;
                    r.status = pmr_pkg::ST_OVERFLOW;
                end
                else
                begin
                    if (slot < 0)
                    begin
                        slot = colors_used;
                        merged_rgb[slot] = rgb;
                        colors_used++;
                        r.is_new = 1'b1;
                    end
                    if (large_side)
                    begin
                        large_slots[large_cnt] = slot[IDX_W-1:0];
                        large_cnt++;
                    end
                    else
                    begin
                        small_slots[small_cnt] = slot[IDX_W-1:0];
                        small_cnt++;
                    end
                end
            end
        end
        else if (it.pixel_index >= (large_side ? large_cnt : small_cnt))
        begin
            job_dead = 1'b1;
            r.status = pmr_pkg::ST_RANGE;
        end
        else
            slot = large_side ? large_slots[it.pixel_index] : small_slots[it.pixel_index];
        if (slot >= 0)
        begin
            r.merged_index = slot[IDX_W-1:0];
            {r.red, r.green, r.blue} = merged_rgb[slot];
        end
        r.merged_count = colors_used[CNT_W-1:0];
        return r;
    endfunction

    task automatic queue_item(input logic [OPC_W-1:0] op, input logic [RGB_W-1:0] rgb,
                              input logic [IDX_W-1:0] pix, input bit last);
        pal_item_t it;
        if (noisy && $urandom_range(0, 39) == 0)
        begin
            it = {OPC_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), RGB_W'($urandom),
                  IDX_W'($urandom), 1'($urandom)};
            items_to_send.push_back(it);
        end
        it = {op, rgb, pix, last};
        items_to_send.push_back(it);
        if (op <= pmr_pkg::OP_SMALL_PIXEL)
            work_items++;
    endtask

    task automatic big_job(input int kind);
        logic [RGB_W-1:0] shades [PAL_N];
        logic [OPC_W-1:0] entry_op;
        logic [OPC_W-1:0] pixel_op;
        int               k;
        queue_item(pmr_pkg::OP_CLEAR, RGB_W'($urandom), IDX_W'($urandom), 1'b0);
        if (kind == JOB_FILL_MERGED)
        begin
            for (k = 0; k < PAL_N; k++)
            begin
                shades[k] = {CLR_W'(k), 16'($urandom)};
                queue_item(pmr_pkg::OP_LARGE_ENTRY, shades[k], IDX_W'($urandom),
                           k == PAL_N - 1);
            end
            queue_item(pmr_pkg::OP_LARGE_PIXEL, RGB_W'($urandom), IDX_W'(PAL_N - 1), 1'b0);
            queue_item(pmr_pkg::OP_LARGE_PIXEL, RGB_W'($urandom), '0, 1'b0);
            for (k = 0; k < 4; k++)
                queue_item(pmr_pkg::OP_LARGE_PIXEL, RGB_W'($urandom),
                           IDX_W'($urandom_range(0, PAL_N - 1)), k == 3);
            queue_item(pmr_pkg::OP_SMALL_ENTRY, shades[$urandom_range(0, PAL_N - 1)], '0, 1'b0);
            queue_item(pmr_pkg::OP_SMALL_PIXEL, RGB_W'($urandom), '0, 1'b0);
            queue_item(pmr_pkg::OP_SMALL_ENTRY,
                       {shades[0][RGB_W-1:CLR_W], shades[0][CLR_W-1:0] + 8'd1}, '0, 1'b1);
            queue_item(pmr_pkg::OP_SMALL_PIXEL, RGB_W'($urandom), '0, 1'b1);
        end
        else
        begin
            entry_op = (kind == JOB_OVERFILL_LARGE) ? pmr_pkg::OP_LARGE_ENTRY
                                                    : pmr_pkg::OP_SMALL_ENTRY;
            pixel_op = (kind == JOB_OVERFILL_LARGE) ? pmr_pkg::OP_LARGE_PIXEL
                                                    : pmr_pkg::OP_SMALL_PIXEL;
            for (k = 0; k < 3; k++)
                shades[k] = RGB_W'($urandom);
            if (kind == JOB_OVERFILL_SMALL)
                queue_item(pmr_pkg::OP_LARGE_ENTRY, shades[0], '0, 1'b1);
            for (k = 0; k <= PAL_N; k++)
            begin
                queue_item(entry_op, shades[k % 3], IDX_W'($urandom), k == PAL_N - 1);
                if (k == PAL_N - 1)
                    queue_item(pixel_op, RGB_W'($urandom), IDX_W'(PAL_N - 1), 1'b1);
            end
            queue_item(pixel_op, RGB_W'($urandom), '0, 1'b1);
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            item_bus.valid <= 1'b0;
        else if (!item_bus.valid || item_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_bus.valid <= 1'b0;
            end
            else if (items_to_send.size() > 0)
            begin
                on_bus = items_to_send.pop_front();
                item_bus.opcode      <= on_bus.opcode;
                item_bus.red         <= on_bus.red;
                item_bus.green       <= on_bus.green;
                item_bus.blue        <= on_bus.blue;
                item_bus.pixel_index <= on_bus.pixel_index;
                item_bus.last_in_run <= on_bus.last_in_run;
                item_bus.valid       <= 1'b1;
                if ($urandom_range(0, 149) == 0)
                    src_steady = !src_steady;
                if (!src_steady)
                    gap_left = draw_gap();
            end
            else
                item_bus.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 599) == 0)
                sink_steady = !sink_steady;
            if (stall_left == 0 && !sink_steady && $urandom_range(0, 3) == 0)
                stall_left = draw_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pal_result_t seen;
        pal_result_t want;
        item_taken = 1'b0;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                seen = {result_bus.merged_index, result_bus.is_new, result_bus.out_red,
                        result_bus.out_green, result_bus.out_blue, result_bus.merged_count,
                        result_bus.status, result_bus.last_out};
                if (merged_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with no item pending: %s", $realtime,
                                 describe(seen));
                end
                else
                begin
                    want = merged_results_due.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                                     describe(want), describe(seen));
                    end
                end
            end
            if (item_bus.valid && item_bus.ready)
            begin
                item_taken = 1'b1;
                merged_results_due.push_back(predict_merge(on_bus));
                accepted++;
            end
        end
    end

    initial
    begin
        logic [RGB_W-1:0] pool [16];
        logic [RGB_W-1:0] shade;
        int               k;
        int               npool;
        int               nl;
        int               ns;
        int               np;
        int               cnt;
        int               pix;
        int               job_no;
        bit               small_side;

        item_bus.valid = 1'b0;
        item_bus.opcode = pmr_pkg::OP_CLEAR;
        item_bus.red = '0;
        item_bus.green = '0;
        item_bus.blue = '0;
        item_bus.pixel_index = '0;
        item_bus.last_in_run = 1'b0;
        result_bus.ready = 1'b0;

        queue_item(pmr_pkg::OP_LARGE_PIXEL, RGB_W'($urandom), '0, 1'b0);
        queue_item(pmr_pkg::OP_LARGE_ENTRY, 24'h000000, '0, 1'b0);
        queue_item(pmr_pkg::OP_CLEAR, 24'hffffff, 8'hff, 1'b0);
        queue_item(OP_UNUSED_FIRST, RGB_W'($urandom), '0, 1'b0);
        queue_item(OP_UNUSED_LAST, RGB_W'($urandom), 8'hff, 1'b1);
        queue_item(pmr_pkg::OP_LARGE_ENTRY, 24'h000000, '0, 1'b0);
        queue_item(pmr_pkg::OP_LARGE_ENTRY, 24'hffffff, 8'hff, 1'b0);
        queue_item(pmr_pkg::OP_LARGE_ENTRY, 24'h000000, '0, 1'b0);
        queue_item(pmr_pkg::OP_LARGE_ENTRY, 24'hff00ff, '0, 1'b1);
        queue_item(pmr_pkg::OP_SMALL_ENTRY, 24'hffffff, '0, 1'b0);
        queue_item(pmr_pkg::OP_SMALL_ENTRY, 24'h5a3c96, '0, 1'b1);
        queue_item(pmr_pkg::OP_LARGE_ENTRY, 24'h00ff00, '0, 1'b0);
        queue_item(pmr_pkg::OP_LARGE_PIXEL, RGB_W'($urandom), 8'd0, 1'b0);
        queue_item(pmr_pkg::OP_LARGE_PIXEL, RGB_W'($urandom), 8'd3, 1'b0);
        queue_item(pmr_pkg::OP_SMALL_PIXEL, RGB_W'($urandom), 8'd1, 1'b0);
        queue_item(pmr_pkg::OP_SMALL_PIXEL, RGB_W'($urandom), 8'd0, 1'b1);
        queue_item(pmr_pkg::OP_SMALL_PIXEL, RGB_W'($urandom), 8'd2, 1'b0);
        queue_item(pmr_pkg::OP_SMALL_ENTRY, 24'h102030, '0, 1'b0);
        queue_item(pmr_pkg::OP_LARGE_PIXEL, RGB_W'($urandom), 8'd0, 1'b0);
        queue_item(pmr_pkg::OP_CLEAR, RGB_W'($urandom), '0, 1'b1);
        queue_item(pmr_pkg::OP_SMALL_ENTRY, 24'h123456, '0, 1'b1);
        queue_item(pmr_pkg::OP_SMALL_PIXEL, RGB_W'($urandom), 8'hff, 1'b1);
        queue_item(pmr_pkg::OP_CLEAR, RGB_W'($urandom), '0, 1'b0);

        noisy = 1'b1;
        job_no = 0;
        while (work_items < ITEM_TARGET)
        begin
            if (job_no == 3)
                big_job(JOB_FILL_MERGED);
            else if (job_no == 9)
                big_job(JOB_OVERFILL_LARGE);
            else if (job_no == 15)
                big_job(JOB_OVERFILL_SMALL);
            else
            begin
                npool = $urandom_range(1, 10);
                for (k = 0; k < npool; k++)
                    case ($urandom_range(0, 9))
                        0: pool[k] = '0;
                        1: pool[k] = '1;
                        default: pool[k] = RGB_W'($urandom);
                    endcase
                queue_item(pmr_pkg::OP_CLEAR, RGB_W'($urandom), IDX_W'($urandom),
                           1'($urandom));
                nl = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                ns = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if ($urandom_range(0, 19) == 0)
                    queue_item(pmr_pkg::OP_LARGE_PIXEL, RGB_W'($urandom), IDX_W'($urandom),
                               1'b0);
                for (k = 0; k < nl; k++)
                    queue_item(pmr_pkg::OP_LARGE_ENTRY, pool[$urandom_range(0, npool - 1)],
                               IDX_W'($urandom), (k == nl - 1) || ($urandom_range(0, 15) == 0));
                for (k = 0; k < ns; k++)
                begin
                    shade = ($urandom_range(0, 2) == 0) ? RGB_W'($urandom)
                                                        : pool[$urandom_range(0, npool - 1)];
                    queue_item(pmr_pkg::OP_SMALL_ENTRY, shade, IDX_W'($urandom),
                               (k == ns - 1) || ($urandom_range(0, 15) == 0));
                end
                if (ns > 0 && $urandom_range(0, 11) == 0)
                    queue_item(pmr_pkg::OP_LARGE_ENTRY, pool[0], IDX_W'($urandom), 1'b0);
                np = $urandom_range(4, 30);
                for (k = 0; k < np; k++)
                begin
                    small_side = 1'($urandom);
                    cnt = small_side ? ns : nl;
                    if (cnt == 0 || $urandom_range(0, 79) == 0)
                        pix = $urandom_range(cnt, 255);
                    else
                        pix = $urandom_range(0, cnt - 1);
                    queue_item(small_side ? pmr_pkg::OP_SMALL_PIXEL : pmr_pkg::OP_LARGE_PIXEL,
                               RGB_W'($urandom), IDX_W'(pix),
                               (k == np - 1) || ($urandom_range(0, 15) == 0));
                end
            end
            job_no++;
        end
        queued_total = items_to_send.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        fork
            begin
                while (accepted < queued_total || merged_results_due.size() != 0)
                    @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
                drained = 1'b1;
            end
            begin
                while (cycle_count < CYCLE_LIMIT)
                begin
                    @(posedge clk);
                    cycle_count++;
                end
            end
        join_any

        if (drained && mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
